// ===== rtl/mhse_pkg.sv =====
// shared types and constants for the min heap sift-down / extract block
// no dependencies; used by the top, datapath and controller under rtl (not by mhse_ram)
package mhse_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int CMD_W        = 2;
  localparam int IDX_W        = 4;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 40;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_SIFT    = 2'd1,
    CMD_EXTRACT = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_CMP,
    ST_KIDS,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic app_write;
    logic set_full;
    logic set_empty;
    logic start_sift;
    logic start_extract;
    logic load_cur;
    logic rd_kids;
    logic step;
    logic finish;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t op;
    logic idx_ok;
    logic is_full;
    logic is_empty;
    logic at_rest;
  } dp_status_t;

endpackage

// ===== rtl/min_heap_sift_down_extract.sv =====
// sequence: append, no-op, empty extract and out-of-range sift go from decode to ST_DONE;
// others pass through load, then a compare and a child read for each of the L
// levels they move down, L <= floor(log2(CAPACITY)); the store's child reads are registered
// throughput: one item at a time; a new beat is taken the cycle after the result is loaded
// reset: entry count and handshake state clear synchronously; store contents stay undefined
module min_heap_sift_down_extract #(
  parameter int CAPACITY = mhse_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command[1:0], sift_index[5:2], new_value[37:6], zero pad[39:38]
  input  logic [mhse_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // min_value[31:0], was_empty[32], was_full[33], entry_count[38:34], zero pad[39]
  output logic [mhse_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  mhse_pkg::ctrl_cmd_t  cmd;
  mhse_pkg::dp_status_t status;

  mhse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mhse_datapath #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // one item in flight: no second beat right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // empty extract reports -1 and no entries
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[32]) |-> (out_tdata[31:0] == 32'hFFFF_FFFF
      && out_tdata[38:34] == 5'd0 && !out_tdata[33]))
    else $error("empty extract result malformed");

  // a dropped append returns no value
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33]) |-> (out_tdata[31:0] == 32'hFFFF_FFFF))
    else $error("full append result carries a value");
`endif

endmodule

// ===== rtl/mhse_ram.sv =====
// heap store: one write port, two read ports with registered read data
// depends on nothing but its parameters
module mhse_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wa,
  input  logic [DATA_W-1:0] wd,
  input  logic              re,
  input  logic [ADDR_W-1:0] ra,
  input  logic [ADDR_W-1:0] rb,
  output logic [DATA_W-1:0] rd_a,
  output logic [DATA_W-1:0] rd_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_a <= mem[ra];
      rd_b <= mem[rb];
    end
  end

endmodule

// ===== rtl/mhse_datapath.sv =====
// datapath: command/result registers, entry count, sift position and value, heap store
// depends on mhse_pkg and mhse_ram
module mhse_datapath #(
  parameter int CAPACITY = mhse_pkg::DEF_CAPACITY,
  parameter int ADDR_W   = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mhse_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  mhse_pkg::ctrl_cmd_t               cmd,
  output mhse_pkg::dp_status_t              status,
  output logic [mhse_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int CW = (ADDR_W + 2 > mhse_pkg::IDX_W) ? ADDR_W + 2 : mhse_pkg::IDX_W;
  localparam int VW = mhse_pkg::VALUE_W;

  mhse_pkg::cmd_t              op_r;
  logic [mhse_pkg::IDX_W-1:0]  idx_r;
  logic signed [VW-1:0]        val_r;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]           pos_r, pos_nxt;
  logic signed [VW-1:0]        cur_r;
  logic signed [VW-1:0]        minv_r;
  logic                        empty_r;
  logic                        full_r;
  logic [mhse_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic                        ram_we, ram_re;
  logic [ADDR_W-1:0]           ram_wa, ram_ra, ram_rb;
  logic [VW-1:0]               ram_wd, ram_rd_a, ram_rd_b;

  logic [CW-1:0]               cnt_w, pos_w, idx_w, lt_w, rt_w, last_w, best_w;
  logic                        lt_ok, rt_ok, take_l, take_r;
  logic signed [VW-1:0]        left_v, right_v, best_v;
  logic [CNT_W+mhse_pkg::COUNT_W-1:0] cnt_ext;

  mhse_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W),
    .DATA_W (VW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .wa   (ram_wa),
    .wd   (ram_wd),
    .re   (ram_re),
    .ra   (ram_ra),
    .rb   (ram_rb),
    .rd_a (ram_rd_a),
    .rd_b (ram_rd_b)
  );

  assign cnt_w  = CW'(cnt_r);
  assign pos_w  = CW'(pos_r);
  assign idx_w  = CW'(idx_r);
  assign lt_w   = (pos_w << 1) + CW'(1);
  assign rt_w   = lt_w + CW'(1);
  assign last_w = cnt_w - CW'(1);
  assign lt_ok  = lt_w < cnt_w;
  assign rt_ok  = rt_w < cnt_w;

  assign left_v  = $signed(ram_rd_a);
  assign right_v = $signed(ram_rd_b);

  // left child wins a tie: right only when strictly below the running best
  always_comb begin
    best_v = cur_r;
    take_l = 1'b0;
    take_r = 1'b0;
    if (lt_ok && (left_v < cur_r)) begin
      best_v = left_v;
      take_l = 1'b1;
    end
    if (rt_ok && (right_v < best_v)) begin
      best_v = right_v;
      take_r = 1'b1;
      take_l = 1'b0;
    end
  end

  assign best_w = take_r ? rt_w : lt_w;

  assign status.op       = op_r;
  assign status.idx_ok   = idx_w < cnt_w;
  assign status.is_full  = (cnt_r == CNT_W'(CAPACITY));
  assign status.is_empty = (cnt_r == '0);
  assign status.at_rest  = !take_l && !take_r;

  // store ports
  always_comb begin
    ram_we = 1'b0;
    ram_wa = pos_r;
    ram_wd = cur_r;
    ram_re = 1'b0;
    ram_ra = lt_w[ADDR_W-1:0];
    ram_rb = rt_w[ADDR_W-1:0];
    if (cmd.app_write) begin
      ram_we = 1'b1;
      ram_wa = cnt_w[ADDR_W-1:0];
      ram_wd = val_r;
    end else if (cmd.step) begin
      ram_we = 1'b1;
      ram_wd = best_v;
    end else if (cmd.finish) begin
      ram_we = 1'b1;
    end
    if (cmd.start_sift) begin
      ram_re = 1'b1;
      ram_ra = idx_w[ADDR_W-1:0];
    end else if (cmd.start_extract) begin
      ram_re = 1'b1;
      ram_ra = '0;
      ram_rb = last_w[ADDR_W-1:0];
    end else if (cmd.rd_kids) begin
      ram_re = 1'b1;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.app_write) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.start_extract) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.start_sift) begin
      pos_nxt = idx_w[ADDR_W-1:0];
    end else if (cmd.start_extract) begin
      pos_nxt = '0;
    end else if (cmd.step) begin
      pos_nxt = best_w[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.latch_in) begin
      op_r    <= mhse_pkg::cmd_t'(in_tdata[1:0]);
      idx_r   <= in_tdata[5:2];
      val_r   <= $signed(in_tdata[37:6]);
      minv_r  <= mhse_pkg::EMPTY_VALUE;
      empty_r <= 1'b0;
      full_r  <= 1'b0;
    end
    if (cmd.set_full) begin
      full_r <= 1'b1;
    end
    if (cmd.set_empty) begin
      empty_r <= 1'b1;
    end
    // extract: root read on port a, last entry on port b moves to the root
    if (cmd.load_cur) begin
      if (op_r == mhse_pkg::CMD_EXTRACT) begin
        cur_r  <= $signed(ram_rd_b);
        minv_r <= $signed(ram_rd_a);
      end else begin
        cur_r <= $signed(ram_rd_a);
      end
    end
    if (cmd.load_out) begin
      out_data_r <= {1'b0, cnt_ext[mhse_pkg::COUNT_W-1:0], full_r, empty_r, minv_r};
    end
  end

  assign cnt_ext   = (CNT_W + mhse_pkg::COUNT_W)'(cnt_r);
  assign out_tdata = out_data_r;

endmodule

// ===== rtl/mhse_ctrl.sv =====
// controller: sequences decode, sift levels and result hand-off
// depends on mhse_pkg
module mhse_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  mhse_pkg::dp_status_t  status,
  output mhse_pkg::ctrl_cmd_t   cmd
);

  mhse_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhse_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      mhse_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = mhse_pkg::ST_DECODE;
        end
      end
      mhse_pkg::ST_DECODE: begin
        state_nxt = mhse_pkg::ST_DONE;
        case (status.op)
          mhse_pkg::CMD_APPEND: begin
            if (status.is_full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.app_write = 1'b1;
            end
          end
          mhse_pkg::CMD_SIFT: begin
            if (status.idx_ok) begin
              cmd.start_sift = 1'b1;
              state_nxt      = mhse_pkg::ST_LOAD;
            end
          end
          mhse_pkg::CMD_EXTRACT: begin
            if (status.is_empty) begin
              cmd.set_empty = 1'b1;
            end else begin
              cmd.start_extract = 1'b1;
              state_nxt         = mhse_pkg::ST_LOAD;
            end
          end
          default: begin
            state_nxt = mhse_pkg::ST_DONE;
          end
        endcase
      end
      mhse_pkg::ST_LOAD: begin
        cmd.load_cur = 1'b1;
        cmd.rd_kids  = 1'b1;
        state_nxt    = mhse_pkg::ST_CMP;
      end
      mhse_pkg::ST_CMP: begin
        if (status.at_rest) begin
          cmd.finish = 1'b1;
          state_nxt  = mhse_pkg::ST_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = mhse_pkg::ST_KIDS;
        end
      end
      mhse_pkg::ST_KIDS: begin
        cmd.rd_kids = 1'b1;
        state_nxt   = mhse_pkg::ST_CMP;
      end
      mhse_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = mhse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mhse_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== sim/min_heap_sift_down_extract_test.sv =====
// self-checking bench for min_heap_sift_down_extract: directed beats, then random heap rounds
// a scoreboard class tracks its own heap and checks every result beat field by field
// depends on rtl/mhse_pkg.sv and rtl/min_heap_sift_down_extract.sv
module min_heap_sift_down_extract_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH    = mhse_pkg::DEF_CAPACITY;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TARGET_BEATS   = 500;

  typedef struct packed {
    logic signed [mhse_pkg::VALUE_W-1:0] min_value;
    logic                                was_empty;
    logic                                was_full;
    logic [mhse_pkg::COUNT_W-1:0]        entry_count;
  } heap_result_t;

  class heap_scoreboard;
    logic signed [mhse_pkg::VALUE_W-1:0] slots [STORE_DEPTH];
    logic [mhse_pkg::COUNT_W-1:0]        fill;
    heap_result_t                        want_q [$];
    int                                  errors;

    function new();
      fill   = '0;
      errors = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // push the value at pos down until no child is smaller; left child wins a tie
    function void sink(int unsigned pos);
      int unsigned lt;
      int unsigned rt;
      int unsigned best;
      logic signed [mhse_pkg::VALUE_W-1:0] tmp;
      while (pos < fill) begin
        lt   = 2 * pos + 1;
        rt   = lt + 1;
        best = pos;
        if (lt < fill && slots[lt] < slots[best]) best = lt;
        if (rt < fill && slots[rt] < slots[best]) best = rt;
        if (best == pos) break;
        tmp         = slots[pos];
        slots[pos]  = slots[best];
        slots[best] = tmp;
        pos         = best;
      end
    endfunction

    function void note_input(mhse_pkg::cmd_t code, logic [mhse_pkg::IDX_W-1:0] ix,
                             logic signed [mhse_pkg::VALUE_W-1:0] v);
      heap_result_t want;
      int unsigned last;
      want.min_value = mhse_pkg::EMPTY_VALUE;
      want.was_empty = 1'b0;
      want.was_full  = 1'b0;
      case (code)
        mhse_pkg::CMD_APPEND: begin
          if (fill >= STORE_DEPTH) begin
            want.was_full = 1'b1;
          end else begin
            slots[fill] = v;
            fill        = fill + 1'b1;
          end
        end
        mhse_pkg::CMD_SIFT: begin
          if (ix < fill) sink(ix);
        end
        mhse_pkg::CMD_EXTRACT: begin
          if (fill == 0) begin
            want.was_empty = 1'b1;
          end else begin
            last        = fill - 1;
            want.min_value = slots[0];
            slots[0]    = slots[last];
            slots[last] = want.min_value;
            fill        = last[mhse_pkg::COUNT_W-1:0];
            sink(0);
            want.min_value = slots[last];
          end
        end
        default: ;
      endcase
      want.entry_count = fill;
      want_q.push_back(want);
    endfunction

    function void check_result(logic [mhse_pkg::OUT_TDATA_W-1:0] beat);
      heap_result_t got;
      heap_result_t want;
      got.min_value   = beat[31:0];
      got.was_empty   = beat[32];
      got.was_full    = beat[33];
      got.entry_count = beat[38:34];
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, beat);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got.min_value !== want.min_value) begin
        $display("%0t: min_value expected %0d got %0d", $time, want.min_value, got.min_value);
        errors++;
      end
      if (got.was_empty !== want.was_empty) begin
        $display("%0t: was_empty expected %b got %b", $time, want.was_empty, got.was_empty);
        errors++;
      end
      if (got.was_full !== want.was_full) begin
        $display("%0t: was_full expected %b got %b", $time, want.was_full, got.was_full);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                 got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [mhse_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [mhse_pkg::OUT_TDATA_W-1:0] out_tdata;

  heap_scoreboard sb;
  logic           calm = 1'b0;
  int             sent = 0;
  int             quiet_cycles = 0;

  min_heap_sift_down_extract dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random back-pressure, checking and the no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("min_heap_sift_down_extract_test: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    out_tready <= calm || ($urandom_range(99) >= 8);
  end

  function automatic logic [mhse_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return 32'($urandom_range(6)) - 32'd3;  // narrow range gives ties
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input mhse_pkg::cmd_t code, input logic [mhse_pkg::IDX_W-1:0] ix,
                           input logic [mhse_pkg::VALUE_W-1:0] v);
    while (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, v, ix, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(code, ix, v);
    sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // fill, heapify bottom-up (most of the time), then extracts mixed with stray appends
  task automatic heap_round(input int unsigned fills);
    int unsigned k;
    int          i;
    for (k = 0; k < fills; k++)
      send_beat(mhse_pkg::CMD_APPEND, 4'($urandom_range(15)), pick_value());
    if ($urandom_range(3) != 0) begin
      for (i = int'(sb.fill) / 2 - 1; i >= 0; i--)
        send_beat(mhse_pkg::CMD_SIFT, 4'(i), pick_value());
    end
    k = sb.fill + $urandom_range(2);
    repeat (k) begin
      if ($urandom_range(9) == 0)
        send_beat(mhse_pkg::CMD_APPEND, 4'($urandom_range(15)), pick_value());
      else
        send_beat(mhse_pkg::CMD_EXTRACT, 4'($urandom_range(15)), pick_value());
    end
  endtask

  initial begin
    int unsigned rounds;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty heap, no-op command, tie between children, value extremes
    send_beat(mhse_pkg::CMD_EXTRACT, 4'd0, 32'd0);
    send_beat(mhse_pkg::CMD_SIFT, 4'd0, 32'hffff_ffff);
    send_beat(mhse_pkg::CMD_NOP, 4'd15, 32'h5555_aaaa);
    send_beat(mhse_pkg::CMD_APPEND, 4'd0, 32'd5);
    send_beat(mhse_pkg::CMD_APPEND, 4'd0, 32'd3);
    send_beat(mhse_pkg::CMD_APPEND, 4'd0, 32'd3);
    send_beat(mhse_pkg::CMD_SIFT, 4'd0, 32'd0);
    send_beat(mhse_pkg::CMD_SIFT, 4'd12, 32'd0);
    send_beat(mhse_pkg::CMD_EXTRACT, 4'd0, 32'd0);
    send_beat(mhse_pkg::CMD_EXTRACT, 4'd0, 32'd0);
    send_beat(mhse_pkg::CMD_EXTRACT, 4'd0, 32'd0);
    send_beat(mhse_pkg::CMD_EXTRACT, 4'd0, 32'd0);
    send_beat(mhse_pkg::CMD_APPEND, 4'd0, 32'h7fff_ffff);
    send_beat(mhse_pkg::CMD_APPEND, 4'd0, 32'h8000_0000);
    send_beat(mhse_pkg::CMD_APPEND, 4'd0, 32'd0);
    send_beat(mhse_pkg::CMD_APPEND, 4'd0, 32'hffff_ffff);
    send_beat(mhse_pkg::CMD_SIFT, 4'd15, 32'd0);
    send_beat(mhse_pkg::CMD_SIFT, 4'd1, 32'd0);
    send_beat(mhse_pkg::CMD_SIFT, 4'd0, 32'd0);
    send_beat(mhse_pkg::CMD_EXTRACT, 4'd0, 32'd0);
    send_beat(mhse_pkg::CMD_NOP, 4'd0, 32'd0);
    wait_drained();

    // random: mostly well-formed heap rounds, some raw noise; first round overfills the store
    rounds = 0;
    while (sent < TARGET_BEATS) begin
      calm = (sent >= 200 && sent < 300);
      if (rounds == 0 || $urandom_range(9) < 7) begin
        heap_round(rounds == 0 ? 18 : $urandom_range(1, 17));
      end else begin
        repeat ($urandom_range(1, 8))
          send_beat(mhse_pkg::cmd_t'($urandom_range(3)), 4'($urandom_range(15)), $urandom);
      end
      if (rounds == 10) wait_drained();
      rounds++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("min_heap_sift_down_extract_test: done, clean");
    else
      $display("min_heap_sift_down_extract_test: done, errors");
    $finish;
  end

endmodule
